/* rtl/sha384_pkg.sv */
// SHA-384 package: constants, round table, state type and mixing functions.
// Used by the top-level RTL file of the sha384_block_hash block.
`default_nettype none
package sha384_pkg;

  localparam int unsigned Rounds    = 80;
  localparam int unsigned BlkWords  = 16;
  localparam int unsigned HashWords = 8;
  localparam int unsigned DigWords  = 6;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StLoad,
    StRound,
    StAdd,
    StOut
  } state_e;

  function automatic logic [63:0] init_hash(input logic [2:0] idx);
    logic [63:0] r;
    begin
      case (idx)
        3'd0: r = 64'hcbbb9d5dc1059ed8;
        3'd1: r = 64'h629a292a367cd507;
        3'd2: r = 64'h9159015a3070dd17;
        3'd3: r = 64'h152fecd8f70e5939;
        3'd4: r = 64'h67332667ffc00b31;
        3'd5: r = 64'h8eb44a8768581511;
        3'd6: r = 64'hdb0c2e0d64f98fa7;
        default: r = 64'h47b5481dbefa4fa4;
      endcase
      return r;
    end
  endfunction

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] bsig0(input logic [63:0] x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction
  function automatic logic [63:0] bsig1(input logic [63:0] x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction
  function automatic logic [63:0] ssig0(input logic [63:0] x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction
  function automatic logic [63:0] ssig1(input logic [63:0] x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage
`default_nettype wire

/* rtl/sha384_block_hash_top.sv */
// SHA-384 block hash core, top level.
// Depends on sha384_pkg and sha384_ram.
//
// Usage: the input channel carries one 64-bit message word per transaction
// (in_valid_i / in_stall_o), with start_req_i on the first word of a message
// and final_block_i on the last block. Software pads the message. Sixteen
// words form a block; words 0..14 are stored and the core takes the next
// word at once. After the sixteenth word the core runs the compression:
// it reads the hash words into the working variables (one read-ahead step,
// 8 loads), runs the 80 rounds (one round per cycle, the schedule memory
// read one round ahead), then adds the working variables back (one
// read-ahead step, 8 writes).
// On a final block the six digest words follow as six output transactions
// (out_valid_o / out_stall_i), index 0..5, last_o on the sixth, one a cycle
// when the receiver does not stall. A stall on the output holds the current
// word and the core waits; no input is taken until the digest is drained.
// Reset: asynchronous, active low. Hash words read as the initial values
// until first written (per-entry valid bits), the counters clear, no result
// is pending. The schedule memory needs no clearing.
`default_nettype none
module sha384_block_hash_top #(
  parameter int unsigned ROUNDS = sha384_pkg::Rounds
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         start_req_i,
  input  wire  [63:0] word_i,
  input  wire         final_block_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [63:0] digest_word_o,
  output logic [2:0]  digest_index_o,
  output logic        last_o
);
  import sha384_pkg::*;

  localparam int unsigned RcW = $clog2(ROUNDS + 1);

  state_e state_q, state_d;

  logic [3:0]     wcnt_q, wcnt_d;
  logic [RcW-1:0] rcnt_q, rcnt_d;
  logic [3:0]     idx_q, idx_d;     // copy / add / output index
  logic           final_q, final_d;
  logic [7:0]     hvalid_q, hvalid_d;

  // Working variables a..h as a register file of the round unit.
  logic [63:0] v_q [8];
  logic [63:0] v_d [8];

  // Schedule memory: 16 words. Four read ports are needed per round
  // (t-2, t-7, t-15, t), so the ring lives in four copies written together.
  logic        s_we;
  logic [3:0]  s_waddr;
  logic [63:0] s_wdata;
  logic [3:0]  s_raddr [4];
  logic [63:0] s_rdata [4];

  for (genvar g = 0; g < 4; g++) begin : g_sched
    sha384_ram #(.Width(64), .Depth(BlkWords)) u_sched (
      .clk_i   (clk_i),
      .we_i    (s_we),
      .waddr_i (s_waddr),
      .wdata_i (s_wdata),
      .raddr_i (s_raddr[g]),
      .rdata_o (s_rdata[g])
    );
  end

  // Hash memory: 8 words, read-modify-write, one entry a cycle.
  logic        h_we;
  logic [2:0]  h_waddr;
  logic [63:0] h_wdata;
  logic [2:0]  h_raddr;
  logic [63:0] h_rdata;
  logic        h_rvalid_q;
  logic [2:0]  h_ridx_q;
  logic [63:0] h_val;

  sha384_ram #(.Width(64), .Depth(HashWords)) u_hash (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  // Entries not yet valid read as the initial hash.
  assign h_val = h_rvalid_q ? h_rdata : init_hash(h_ridx_q);

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Round datapath. Schedule words for round t were read in the prior cycle.
  logic [63:0] w_new, w_cur, t1, t2, kk;
  logic [6:0]  kidx;
  logic        rnd_exp;
  assign rnd_exp = rcnt_q >= RcW'(BlkWords);
  assign w_new = ssig1(s_rdata[0]) + s_rdata[1] + ssig0(s_rdata[2]) + s_rdata[3];
  assign w_cur = rnd_exp ? w_new : s_rdata[3];
  assign kidx  = 7'(rcnt_q);
  assign kk    = RoundK[kidx];
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + kk + w_cur;
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // Schedule read addresses for the round in rcnt_d (read one ahead).
  logic [3:0] ra;
  always_comb begin
    ra = rcnt_d[3:0];
    s_raddr[0] = ra - 4'd2;
    s_raddr[1] = ra - 4'd7;
    s_raddr[2] = ra - 4'd15;
    s_raddr[3] = ra;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_acc && ((start_req_i ? 4'd0 : wcnt_q) == 4'd15)) state_d = StRead;
      StRead:  state_d = StLoad;
      StLoad:  if (idx_q == 4'd8) state_d = StRound;
      StRound: if (rcnt_q == RcW'(ROUNDS - 1)) state_d = StAdd;
      StAdd:   if (idx_q == 4'd8) state_d = final_q ? StOut : StIdle;
      StOut:   if (out_acc && idx_q == 4'(DigWords - 1)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    wcnt_d   = wcnt_q;
    rcnt_d   = rcnt_q;
    idx_d    = idx_q;
    final_d  = final_q;
    hvalid_d = hvalid_q;
    v_d      = v_q;
    s_we     = 1'b0;
    s_waddr  = rcnt_q[3:0];
    s_wdata  = w_new;
    h_we     = 1'b0;
    h_waddr  = 3'(idx_q - 4'd1);
    h_wdata  = h_val + v_q[0];
    h_raddr  = idx_q[2:0];
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          if (start_req_i) begin
            hvalid_d = '0;
          end
          s_we    = 1'b1;
          s_waddr = start_req_i ? 4'd0 : wcnt_q;
          s_wdata = word_i;
          wcnt_d  = s_waddr + 4'd1;
          final_d = final_block_i;
          idx_d   = '0;
          rcnt_d  = '0;
        end
      end
      StRead: begin
        // hash entry 0 in flight
        idx_d   = 4'd1;
      end
      StLoad: begin
        // shift the hash words into a..h; entry idx-1 arrives now
        for (int i = 0; i < 7; i++) v_d[i] = v_q[i + 1];
        v_d[7] = h_val;
        idx_d  = idx_q + 4'd1;
        if (idx_q == 4'd8) begin
          idx_d = '0;
        end
      end
      StRound: begin
        if (rnd_exp) s_we = 1'b1;
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        rcnt_d = rcnt_q + RcW'(1);
        if (rcnt_q == RcW'(ROUNDS - 1)) begin
          rcnt_d = '0;
          idx_d  = '0;
        end
      end
      StAdd: begin
        // idx 0 issues read 0; idx n writes entry n-1 and rotates a..h
        idx_d = idx_q + 4'd1;
        if (idx_q != 4'd0) begin
          h_we = 1'b1;
          hvalid_d[h_waddr] = 1'b1;
          for (int i = 0; i < 7; i++) v_d[i] = v_q[i + 1];
          v_d[7] = v_q[0];
        end
        if (idx_q == 4'd8) idx_d = '0;
      end
      StOut: begin
        out_valid_o = 1'b1;
        h_raddr = out_acc ? 3'(idx_q + 4'd1) : idx_q[2:0];
        if (out_acc) idx_d = idx_q + 4'd1;
      end
      default: ;
    endcase
  end

  assign digest_word_o  = h_val;
  assign digest_index_o = idx_q[2:0];
  assign last_o         = idx_q == 4'(DigWords - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      wcnt_q     <= '0;
      rcnt_q     <= '0;
      idx_q      <= '0;
      final_q    <= 1'b0;
      hvalid_q   <= '0;
      h_rvalid_q <= 1'b0;
      h_ridx_q   <= '0;
    end else begin
      state_q    <= state_d;
      wcnt_q     <= wcnt_d;
      rcnt_q     <= rcnt_d;
      idx_q      <= idx_d;
      final_q    <= final_d;
      hvalid_q   <= hvalid_d;
      h_rvalid_q <= hvalid_q[h_raddr];
      h_ridx_q   <= h_raddr;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

endmodule
`default_nettype wire

/* rtl/sha384_ram.sv */
// Generic single-port-write RAM with one registered read port.
// No package dependency.
`default_nettype none
module sha384_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/sha384_checker.sv */
// Port-level checker for the SHA-384 core, bound to the top level.
// Depends on sha384_block_hash_top ports only.
`default_nettype none
module sha384_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [63:0] digest_word_o,
  input wire [2:0]  digest_index_o,
  input wire        last_o
);
  // Hold the digest word while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(digest_word_o) && $stable(digest_index_o))
    else $error("digest changed under stall");

  // Last flag marks index five exactly.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (digest_index_o == 3'd5)))
    else $error("last flag mismatch");

  // Input is never taken while a digest is pending.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during digest");

  // Index advances by one after a non-last transaction.
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o &&
    digest_index_o == $past(digest_index_o) + 3'd1)
    else $error("digest index skipped");
endmodule

bind sha384_block_hash_top sha384_checker u_checker (.*);
`default_nettype wire
